// ===== design/vfcm_pkg.sv =====
package vfcm_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_MESH  = 2'd2;

    localparam logic [1:0] KIND_AIR   = 2'd0;
    localparam logic [1:0] KIND_GRASS = 2'd1;
    localparam logic [1:0] KIND_DIRT  = 2'd2;
    localparam logic [1:0] KIND_STONE = 2'd3;

    localparam logic [2:0] DIR_POS_Y = 3'd0;
    localparam logic [2:0] DIR_NEG_Y = 3'd1;
    localparam logic [2:0] DIR_POS_Z = 3'd2;
    localparam logic [2:0] DIR_NEG_Z = 3'd3;
    localparam logic [2:0] DIR_POS_X = 3'd4;
    localparam logic [2:0] DIR_NEG_X = 3'd5;

    localparam int NUM_DIRS = 6;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [1:0] wr_kind;
    } t_mem_ctl;

    typedef struct packed {
        logic [1:0] read_kind;
        logic       has_face;
        logic [3:0] face_x;
        logic [5:0] face_y;
        logic [3:0] face_z;
        logic [2:0] face_dir;
        logic [1:0] face_color;
        logic       last;
    } t_result;

    function automatic logic signed [1:0] f_dx(input logic [2:0] dir);
        logic signed [1:0] d;
        case (dir)
            DIR_POS_X: d = 2'sd1;
            DIR_NEG_X: d = -2'sd1;
            default:   d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] f_dy(input logic [2:0] dir);
        logic signed [1:0] d;
        case (dir)
            DIR_POS_Y: d = 2'sd1;
            DIR_NEG_Y: d = -2'sd1;
            default:   d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] f_dz(input logic [2:0] dir);
        logic signed [1:0] d;
        case (dir)
            DIR_POS_Z: d = 2'sd1;
            DIR_NEG_Z: d = -2'sd1;
            default:   d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/voxel_face_culling_mesher.sv =====
// Voxel grid of 2-bit block types (air, grass, dirt, stone) in one single-port
// memory, laid out {y, z, x}. After reset a clearing pass loads the layered terrain,
// one entry per cycle across 2^(clog2(W)+clog2(H)+clog2(D)) entries (16384 at defaults),
// with s_axis_tready low until it ends. A write is stored at its transfer. A read's
// result passes the memory output register and the wait and emit states. A mesh
// issues seven reads (cell, then +y, -y, +z, -z, +x, -x) one per cycle through the
// memory's only read port, then emits one result per face, or one with no face;
// the next item is taken the cycle after the final result is registered.
// Results sit in an output register, so input is accepted while the last one waits.
module voxel_face_culling_mesher #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 64,
    parameter int GRID_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pos_x[6:0], pos_y[14:7], pos_z[21:15], block_kind[23:22]
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // read_kind[1:0], face_x[5:2], face_y[11:6],
                                       // face_z[15:12], face_dir[18:16], face_color[20:19]
    output logic        m_axis_tuser,  // has_face
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(GRID_HEIGHT) + $clog2(GRID_DEPTH) + $clog2(GRID_WIDTH);

    vfcm_pkg::t_mem_ctl mem_ctl;
    vfcm_pkg::t_result  res;
    logic [AW-1:0]      mem_addr;
    logic [1:0]         rd_kind;
    logic               store_ready;

    vfcm_store #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .GRID_DEPTH (GRID_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_addr   (mem_addr),
        .o_rd_kind(rd_kind),
        .o_ready  (store_ready)
    );

    vfcm_seq #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .GRID_DEPTH (GRID_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_pos_x      (s_axis_tdata[6:0]),
        .i_pos_y      (s_axis_tdata[14:7]),
        .i_pos_z      (s_axis_tdata[21:15]),
        .i_block_kind (s_axis_tdata[23:22]),
        .o_mem_ctl    (mem_ctl),
        .o_mem_addr   (mem_addr),
        .i_rd_kind    (rd_kind),
        .i_store_ready(store_ready),
        .o_valid      (m_axis_tvalid),
        .o_result     (res),
        .i_out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, res.face_color, res.face_dir, res.face_z,
                           res.face_y, res.face_x, res.read_kind};
    assign m_axis_tuser = res.has_face;
    assign m_axis_tlast = res.last;

endmodule

// ===== design/vfcm_store.sv =====
module vfcm_store #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 64,
    parameter int GRID_DEPTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vfcm_pkg::t_mem_ctl i_ctl,
    input  logic [$clog2(GRID_HEIGHT)+$clog2(GRID_DEPTH)+$clog2(GRID_WIDTH)-1:0] i_addr,
    output logic [1:0]         o_rd_kind,
    output logic               o_ready
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int ZW = $clog2(GRID_DEPTH);
    localparam int AW = XW + YW + ZW;
    localparam int ENTRIES = 1 << AW;
    localparam int STONE_TOP = GRID_HEIGHT / 2 - 2;
    localparam int GRASS_Y   = GRID_HEIGHT / 2;

    logic [1:0]    r_mem [ENTRIES];
    logic [1:0]    r_rd_kind;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic [YW-1:0] clr_y;
    logic [1:0]    clr_kind;

    // entries are laid out as {y, z, x}; the clearing pass derives y from the sweep address
    assign clr_y = r_clr_addr[AW-1 -: YW];

    always_comb begin
        if (int'(clr_y) < STONE_TOP) begin
            clr_kind = vfcm_pkg::KIND_STONE;
        end else if (int'(clr_y) < GRASS_Y) begin
            clr_kind = vfcm_pkg::KIND_DIRT;
        end else if (int'(clr_y) == GRASS_Y) begin
            clr_kind = vfcm_pkg::KIND_GRASS;
        end else begin
            clr_kind = vfcm_pkg::KIND_AIR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= clr_kind;
        end else if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wr_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_kind <= r_mem[i_addr];
        end
    end

    assign o_rd_kind = r_rd_kind;
    assign o_ready   = !r_clr_busy;

endmodule

// ===== design/vfcm_seq.sv =====
module vfcm_seq #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 64,
    parameter int GRID_DEPTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [6:0]         i_pos_x,
    input  logic [7:0]         i_pos_y,
    input  logic [6:0]         i_pos_z,
    input  logic [1:0]         i_block_kind,
    output vfcm_pkg::t_mem_ctl o_mem_ctl,
    output logic [$clog2(GRID_HEIGHT)+$clog2(GRID_DEPTH)+$clog2(GRID_WIDTH)-1:0] o_mem_addr,
    input  logic [1:0]         i_rd_kind,
    input  logic               i_store_ready,
    output logic               o_valid,
    output vfcm_pkg::t_result  o_result,
    input  logic               i_out_ready
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int ZW = $clog2(GRID_DEPTH);
    localparam logic signed [8:0] LIM_X = 9'(GRID_WIDTH);
    localparam logic signed [8:0] LIM_Y = 9'(GRID_HEIGHT);
    localparam logic signed [8:0] LIM_Z = 9'(GRID_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_k;
    logic signed [8:0] r_x, r_y, r_z;
    logic              r_is_read;
    logic [1:0]        r_self;
    logic [5:0]        r_mask;
    logic              r_rsp_valid;
    logic [2:0]        r_rsp_idx;
    logic              r_rsp_inr;
    logic              r_ov;
    vfcm_pkg::t_result r_out;

    logic              accept;
    logic [2:0]        dir;
    logic signed [1:0] dx, dy, dz;
    logic signed [8:0] cx, cy, cz;
    logic              inr;
    logic [1:0]        rsp_kind;
    logic [5:0]        faces;
    logic [5:0]        pick;
    logic [5:0]        rest;
    logic [2:0]        pick_dir;
    logic [1:0]        side;
    logic              out_free;
    logic              load;
    vfcm_pkg::t_result emit;

    assign o_ready = (r_state == ST_IDLE) && i_store_ready;
    assign accept  = i_valid && o_ready;

    // one address path: the item's own cell while idle, else the current neighbor
    assign dir = 3'(r_k - 3'd1);
    assign dx  = vfcm_pkg::f_dx(dir);
    assign dy  = vfcm_pkg::f_dy(dir);
    assign dz  = vfcm_pkg::f_dz(dir);

    always_comb begin
        if (r_state == ST_IDLE) begin
            cx = {{2{i_pos_x[6]}}, i_pos_x};
            cy = {i_pos_y[7], i_pos_y};
            cz = {{2{i_pos_z[6]}}, i_pos_z};
        end else begin
            cx = r_x + {{7{dx[1]}}, dx};
            cy = r_y + {{7{dy[1]}}, dy};
            cz = r_z + {{7{dz[1]}}, dz};
        end
    end

    assign inr = !cx[8] && (cx < LIM_X) && !cy[8] && (cy < LIM_Y) &&
                 !cz[8] && (cz < LIM_Z);

    assign o_mem_addr = {cy[YW-1:0], cz[ZW-1:0], cx[XW-1:0]};

    always_comb begin
        o_mem_ctl.wr_kind = i_block_kind;
        o_mem_ctl.wr_en   = accept && (i_action == vfcm_pkg::ACT_WRITE) && inr;
        o_mem_ctl.rd_en   = (accept && ((i_action == vfcm_pkg::ACT_READ) ||
                                        (i_action == vfcm_pkg::ACT_MESH))) ||
                            (r_state == ST_GATHER);
    end

    assign rsp_kind = r_rsp_inr ? i_rd_kind : vfcm_pkg::KIND_AIR;

    // face selection: lowest remaining direction first
    assign faces = (r_self != vfcm_pkg::KIND_AIR) ? r_mask : 6'd0;

    always_comb begin
        pick     = '0;
        pick_dir = vfcm_pkg::DIR_POS_Y;
        for (int j = vfcm_pkg::NUM_DIRS - 1; j >= 0; j--) begin
            if (faces[j]) begin
                pick     = 6'(1) << j;
                pick_dir = 3'(j);
            end
        end
    end

    assign rest = faces & ~pick;
    assign side = (r_self == vfcm_pkg::KIND_GRASS) ? vfcm_pkg::KIND_DIRT : r_self;

    always_comb begin
        emit = '0;
        if (r_is_read) begin
            emit.read_kind = r_self;
            emit.last      = 1'b1;
        end else if (faces == 6'd0) begin
            emit.last = 1'b1;
        end else begin
            emit.has_face = 1'b1;
            emit.face_x   = r_x[3:0];
            emit.face_y   = r_y[5:0];
            emit.face_z   = r_z[3:0];
            emit.face_dir = pick_dir;
            if (pick_dir == vfcm_pkg::DIR_POS_Y) begin
                emit.face_color = vfcm_pkg::KIND_GRASS;
            end else if (pick_dir == vfcm_pkg::DIR_NEG_Y) begin
                emit.face_color = vfcm_pkg::KIND_DIRT;
            end else begin
                emit.face_color = side;
            end
            emit.last = (rest == 6'd0);
        end
    end

    assign out_free = !r_ov || i_out_ready;
    assign load     = (r_state == ST_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        vfcm_pkg::ACT_READ: n_state = ST_WAIT;
                        vfcm_pkg::ACT_MESH: n_state = ST_GATHER;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_GATHER: begin
                if (r_k == 3'(vfcm_pkg::NUM_DIRS)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (load && emit.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= 3'd1;
            r_rsp_valid <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= o_mem_ctl.rd_en;
            if (r_state == ST_IDLE) begin
                r_k <= 3'd1;
            end else if (r_state == ST_GATHER) begin
                r_k <= r_k + 3'd1;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x       <= cx;
            r_y       <= cy;
            r_z       <= cz;
            r_is_read <= (i_action == vfcm_pkg::ACT_READ);
        end
        r_rsp_idx <= (r_state == ST_IDLE) ? 3'd0 : r_k;
        r_rsp_inr <= inr;
        if (r_rsp_valid) begin
            if (r_rsp_idx == 3'd0) begin
                r_self <= rsp_kind;
            end
            for (int j = 0; j < vfcm_pkg::NUM_DIRS; j++) begin
                if (r_rsp_idx == 3'(j + 1)) begin
                    r_mask[j] <= (rsp_kind == vfcm_pkg::KIND_AIR);
                end
            end
        end else if (load && !r_is_read) begin
            r_mask <= rest;
        end
        if (load) begin
            r_out <= emit;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

    a_wait_has_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT |-> r_rsp_valid)
        else $error("no read response in wait state");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && emit.last |=> r_state == ST_IDLE)
        else $error("final result did not release the sequencer");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_mem_ctl.wr_en)
        else $error("store write while an item is in progress");

    a_top_grass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && emit.has_face && emit.face_dir == vfcm_pkg::DIR_POS_Y
            |=> r_out.face_color == vfcm_pkg::KIND_GRASS)
        else $error("top face not grass");

endmodule
